// File: rtl/assert_macros.svh
// assertion helpers for the rtl, included by swr_datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: rtl/swr_pkg.sv
package swr_pkg;

    // remap table depth, also the cap on the sample size
    localparam int MAX_SAMPLES = 64;

    localparam int DATA_W  = 32;
    localparam int SIZE_W  = 7;
    localparam int IDX_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int ENTRY_W = 2 * DATA_W;
    localparam int CFG_A_W = 2;

    localparam int SIZE_MAX = (2 ** SIZE_W) - 1;
    localparam logic [SIZE_W-1:0] SIZE_CAP =
        SIZE_W'((MAX_SAMPLES > SIZE_MAX) ? SIZE_MAX : MAX_SAMPLES);

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_RANGE_LOW   = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_RANGE_HIGH  = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_SAMPLE_SIZE = 2'd2;

    // register reset values
    localparam logic [DATA_W-1:0] RANGE_LOW_RST   = 32'd0;
    localparam logic [DATA_W-1:0] RANGE_HIGH_RST  = 32'd255;
    localparam logic [SIZE_W-1:0] SAMPLE_SIZE_RST = 7'd1;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_DONE  = 2'd2;
    localparam logic [1:0] ERR_SIZE  = 2'd3;

    typedef struct packed {
        logic take;
        logic prep;
        logic check;
        logic step;
        logic write;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] err;
        logic       fill_empty;
        logic       scan_last;
        logic       out_free;
    } status_t;

endpackage

// File: rtl/sample_without_replacement_core.sv
// steps: prep, check, scan of the remap entries held (0 to 63), write back, output
// an item rejected by a check goes straight to output, as it skips the table scan
// one word in flight, a new one is taken once the last goes to the output register
// reset: registers to 0 / 255 / 1, top to 255, counts and output valid cleared
// reset: remap ram contents stay undefined, entries are tracked by a fill count
module sample_without_replacement_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [swr_pkg::CFG_A_W-1:0]         cfg_addr,
    input  logic [swr_pkg::DATA_W-1:0]          cfg_wdata,
    // draw words in
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [swr_pkg::DATA_W-1:0]   draw,
    input  logic                                restart,
    // sample words out
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [swr_pkg::DATA_W-1:0]   sample_value,
    output logic                                last_of_sample,
    output logic [1:0]                          error_code
);

    // controller steps through prep, check, table scan, write back and output;
    // datapath holds the bounds, the top, the counts and the remap ram
    swr_pkg::cmd_t    cmd;
    swr_pkg::status_t sts;

    // sequencer, one word in flight, output register lets the next word in
    swr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // bounds ordering, range checks, serial key search and remap update
    swr_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .draw          (draw),
        .restart       (restart),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .sample_value  (sample_value),
        .last_of_sample(last_of_sample),
        .error_code    (error_code),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

// File: rtl/swr_ram.sv
module swr_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/swr_ctrl.sv
module swr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  swr_pkg::status_t sts,
    output swr_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                priority if (sts.err != swr_pkg::ERR_OK)
                begin
                    state_next = S_OUT;
                end
                else if (sts.fill_empty)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.emit = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/swr_datapath.sv
`include "assert_macros.svh"

module swr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swr_pkg::CFG_A_W-1:0]         cfg_addr,
    input  logic [swr_pkg::DATA_W-1:0]          cfg_wdata,
    input  logic signed [swr_pkg::DATA_W-1:0]   draw,
    input  logic                                restart,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [swr_pkg::DATA_W-1:0]   sample_value,
    output logic                                last_of_sample,
    output logic [1:0]                          error_code,
    input  swr_pkg::cmd_t                       cmd,
    output swr_pkg::status_t                    sts
);

    localparam int DW = swr_pkg::DATA_W;
    localparam int SW = swr_pkg::SIZE_W;
    localparam int IW = swr_pkg::IDX_W;
    localparam int CW = swr_pkg::CNT_W;
    localparam int EW = DW + 2;

    // configuration
    logic [DW-1:0] range_low_reg;
    logic [DW-1:0] range_high_reg;
    logic [SW-1:0] sample_size_reg;

    // item and sample state
    logic [DW-1:0] draw_reg;
    logic          restart_reg;
    logic [DW-1:0] lo_reg;
    logic [DW-1:0] hi_reg;
    logic [SW-1:0] size_reg;
    logic [DW-1:0] top_reg;
    logic [SW-1:0] drawn_reg;
    logic [CW-1:0] fill_reg;
    logic [1:0]    err_reg;

    // scan state
    logic [IW-1:0] cnt_reg;
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [DW-1:0] hit_val_reg;
    logic          top_hit_reg;
    logic [DW-1:0] top_val_reg;
    logic [DW-1:0] result_reg;

    // output word
    logic          out_valid_reg;
    logic [DW-1:0] out_value_reg;
    logic          out_last_reg;
    logic [1:0]    out_err_reg;

    logic          low_is_less;
    logic [DW-1:0] lo_next;
    logic [DW-1:0] hi_next;
    logic [SW-1:0] size_next;
    logic [EW-1:0] span_p1;
    logic [1:0]    err_next;
    logic [DW-1:0] entry_key;
    logic [DW-1:0] entry_val;
    logic [DW-1:0] replaced;
    logic          new_entry;

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [2*DW-1:0]       ram_wdata;
    logic                  ram_re;
    logic [IW-1:0]         ram_raddr;
    logic [2*DW-1:0]       ram_rdata;

    // ordered bounds and capped size
    assign low_is_less = $signed(range_low_reg) < $signed(range_high_reg);
    assign lo_next     = low_is_less ? range_low_reg : range_high_reg;
    assign hi_next     = low_is_less ? range_high_reg : range_low_reg;
    assign size_next   = (sample_size_reg > swr_pkg::SIZE_CAP) ? swr_pkg::SIZE_CAP
                                                               : sample_size_reg;

    // checks in priority order
    assign span_p1 = {{2{hi_reg[DW-1]}}, hi_reg} - {{2{lo_reg[DW-1]}}, lo_reg} + EW'(1);

    always_comb
    begin
        priority if (EW'(size_reg) > span_p1)
        begin
            err_next = swr_pkg::ERR_SIZE;
        end
        else if (drawn_reg >= size_reg)
        begin
            err_next = swr_pkg::ERR_DONE;
        end
        else if ($signed(draw_reg) < $signed(lo_reg) || $signed(draw_reg) > $signed(top_reg))
        begin
            err_next = swr_pkg::ERR_RANGE;
        end
        else
        begin
            err_next = swr_pkg::ERR_OK;
        end
    end

    // remap table, key in the upper half
    assign entry_key = ram_rdata[2*DW-1:DW];
    assign entry_val = ram_rdata[DW-1:0];
    assign replaced  = top_hit_reg ? top_val_reg : top_reg;
    assign new_entry = !hit_reg && (draw_reg != top_reg);

    assign ram_re    = cmd.check || cmd.step;
    assign ram_raddr = cmd.check ? '0 : cnt_reg + IW'(1);
    assign ram_we    = cmd.write && (hit_reg || new_entry);
    assign ram_waddr = hit_reg ? hit_idx_reg : fill_reg[IW-1:0];
    assign ram_wdata = {draw_reg, replaced};

    swr_ram #(
        .WIDTH (2 * DW),
        .DEPTH (swr_pkg::MAX_SAMPLES),
        .ADDR_W(IW)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg   <= swr_pkg::RANGE_LOW_RST;
            range_high_reg  <= swr_pkg::RANGE_HIGH_RST;
            sample_size_reg <= swr_pkg::SAMPLE_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                swr_pkg::REG_RANGE_LOW:   range_low_reg   <= cfg_wdata;
                swr_pkg::REG_RANGE_HIGH:  range_high_reg  <= cfg_wdata;
                swr_pkg::REG_SAMPLE_SIZE: sample_size_reg <= cfg_wdata[SW-1:0];
                default:                  ;
            endcase
        end
    end

    // sample state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg     <= swr_pkg::RANGE_HIGH_RST;
            drawn_reg   <= '0;
            fill_reg    <= '0;
            hit_reg     <= 1'b0;
            top_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.prep && restart_reg)
            begin
                top_reg   <= hi_next;
                drawn_reg <= '0;
                fill_reg  <= '0;
            end
            if (cmd.check)
            begin
                hit_reg     <= 1'b0;
                top_hit_reg <= 1'b0;
            end
            if (cmd.step)
            begin
                if (entry_key == draw_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (entry_key == top_reg)
                begin
                    top_hit_reg <= 1'b1;
                end
            end
            if (cmd.write)
            begin
                top_reg   <= top_reg - DW'(1);
                drawn_reg <= drawn_reg + SW'(1);
                if (new_entry)
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end
        end
    end

    // item payload and scan captures
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            draw_reg    <= draw;
            restart_reg <= restart;
        end
        if (cmd.prep)
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            size_reg <= size_next;
        end
        if (cmd.check)
        begin
            err_reg <= err_next;
            cnt_reg <= '0;
        end
        if (cmd.step)
        begin
            cnt_reg <= cnt_reg + IW'(1);
            if (entry_key == draw_reg)
            begin
                hit_idx_reg <= cnt_reg;
                hit_val_reg <= entry_val;
            end
            if (entry_key == top_reg)
            begin
                top_val_reg <= entry_val;
            end
        end
        if (cmd.write)
        begin
            result_reg <= hit_reg ? hit_val_reg : draw_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_err_reg   <= err_reg;
            out_value_reg <= (err_reg == swr_pkg::ERR_OK) ? result_reg : '0;
            out_last_reg  <= (err_reg == swr_pkg::ERR_OK) && (drawn_reg == size_reg);
        end
    end

    assign sts.err        = err_next;
    assign sts.fill_empty = (fill_reg == '0);
    assign sts.scan_last  = (CW'(cnt_reg) == fill_reg - CW'(1));
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign sample_value   = out_value_reg;
    assign last_of_sample = out_last_reg;
    assign error_code     = out_err_reg;

    `ASSERT_NEVER(a_fill_bound, clk, rst_n, 32'(fill_reg) > 32'(swr_pkg::MAX_SAMPLES))
    `ASSERT_NEVER(a_fill_le_drawn, clk, rst_n, 32'(fill_reg) > 32'(drawn_reg))
    `ASSERT_PROP(a_top_step, clk, rst_n, cmd.write |=> top_reg == $past(top_reg) - DW'(1))

endmodule

// File: dv/sample_without_replacement_core_tb.sv
`timescale 1ns / 1ps

module sample_without_replacement_core_tb;

    // cycles with no word moving on any port before the run is abandoned
    localparam int WATCHDOG_LIMIT = 3000;
    // total draw words offered, directed part included
    localparam int TOTAL_WORDS    = 650;
    // long receiver hold-off, asked for from this many offered words on,
    // once enough words are left in the phase to fill the block
    localparam int HOLD_AT_WORD   = 450;
    localparam int HOLD_CYCLES    = 400;
    // window of words during which neither side idles
    localparam int CALM_FROM      = 200;
    localparam int CALM_TO        = 330;
    localparam longint INT_MAX    = 64'sd2147483647;
    localparam longint INT_MIN    = -64'sd2147483647 - 64'sd1;

    // one result word as the block presents it
    typedef struct packed {
        logic [swr_pkg::DATA_W-1:0] value;
        logic                       last;
        logic [1:0]                 err;
    } sample_word_t;

    // one row of the directed plan: either a register load or a draw word
    typedef struct {
        bit                         is_cfg;
        logic [swr_pkg::DATA_W-1:0] lo_reg;
        logic [swr_pkg::DATA_W-1:0] hi_reg;
        logic [swr_pkg::SIZE_W-1:0] size_reg;
        logic [swr_pkg::DATA_W-1:0] pick;
        bit                         fresh;
        bit                         known;
        sample_word_t               want;
    } plan_row_t;

    logic                               clk            = 1'b0;
    logic                               rst_n          = 1'b0;
    logic                               cfg_we         = 1'b0;
    logic [swr_pkg::CFG_A_W-1:0]        cfg_addr       = '0;
    logic [swr_pkg::DATA_W-1:0]         cfg_wdata      = '0;
    logic                               in_valid       = 1'b0;
    logic                               in_ready;
    logic signed [swr_pkg::DATA_W-1:0]  draw           = '0;
    logic                               restart        = 1'b0;
    logic                               out_valid;
    logic                               out_ready      = 1'b0;
    logic signed [swr_pkg::DATA_W-1:0]  sample_value;
    logic                               last_of_sample;
    logic [1:0]                         error_code;

    sample_without_replacement_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .draw           (draw),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_value   (sample_value),
        .last_of_sample (last_of_sample),
        .error_code     (error_code)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shuffle shadow: registers, top, count and the sparse remap table
    // ------------------------------------------------------------------
    logic [swr_pkg::DATA_W-1:0] low_reg;
    logic [swr_pkg::DATA_W-1:0] high_reg;
    logic [swr_pkg::SIZE_W-1:0] size_reg;
    logic [swr_pkg::DATA_W-1:0] top_q;
    logic [swr_pkg::SIZE_W-1:0] taken_q;
    logic [swr_pkg::DATA_W-1:0] map_key  [swr_pkg::MAX_SAMPLES];
    logic [swr_pkg::DATA_W-1:0] map_val  [swr_pkg::MAX_SAMPLES];
    bit                         map_used [swr_pkg::MAX_SAMPLES];

    // results still owed by the block, oldest first
    sample_word_t pending_samples [$];
    plan_row_t    plan [$];

    int  words_sent   = 0;
    int  mismatches   = 0;
    bit  calm         = 1'b0;
    int  holds_asked  = 0;
    int  holds_served = 0;
    int  hold_left    = 0;
    int  quiet_cycles = 0;
    sample_word_t head_word;

    // bounds are ordered before use, so reversed registers just swap
    function automatic int span_lo();
        int a, b;
        a = low_reg;
        b = high_reg;
        return (a < b) ? a : b;
    endfunction

    function automatic int span_hi();
        int a, b;
        a = low_reg;
        b = high_reg;
        return (a < b) ? b : a;
    endfunction

    // sizes above the table depth saturate
    function automatic int eff_size();
        return (size_reg > swr_pkg::MAX_SAMPLES) ? swr_pkg::MAX_SAMPLES : int'(size_reg);
    endfunction

    function automatic int find_slot(input logic [swr_pkg::DATA_W-1:0] key);
        for (int i = 0; i < swr_pkg::MAX_SAMPLES; i++)
            if (map_used[i] && map_key[i] == key)
                return i;
        return -1;
    endfunction

    // new sample: empty table, top back to the larger bound
    function automatic void open_sample();
        for (int i = 0; i < swr_pkg::MAX_SAMPLES; i++)
            map_used[i] = 1'b0;
        top_q   = span_hi();
        taken_q = '0;
    endfunction

    // one draw through the shuffle; checks in order size, complete, range
    task automatic predict_word(input logic [swr_pkg::DATA_W-1:0] d, input bit fresh,
                                output sample_word_t w);
        int lo, hi, sz, hit, top_hit;
        logic [swr_pkg::DATA_W-1:0] moved;
        if (fresh)
            open_sample();
        w  = '0;
        lo = span_lo();
        hi = span_hi();
        sz = eff_size();
        if (longint'(sz) > longint'(hi) - longint'(lo) + 1)
            w.err = swr_pkg::ERR_SIZE;
        else if (int'(taken_q) >= sz)
            w.err = swr_pkg::ERR_DONE;
        else if ($signed(d) < lo || $signed(d) > $signed(top_q))
            w.err = swr_pkg::ERR_RANGE;
        else
        begin
            hit     = find_slot(d);
            top_hit = find_slot(top_q);
            moved   = (top_hit >= 0) ? map_val[top_hit] : top_q;
            if (hit < 0)
            begin
                w.value = d;
                // drawing the top itself needs no swap record
                if (d != top_q)
                begin
                    for (int i = 0; i < swr_pkg::MAX_SAMPLES; i++)
                    begin
                        if (!map_used[i])
                        begin
                            map_used[i] = 1'b1;
                            map_key[i]  = d;
                            map_val[i]  = moved;
                            break;
                        end
                    end
                end
            end
            else
            begin
                w.value      = map_val[hit];
                map_val[hit] = moved;
            end
            top_q   = top_q - 1'b1;     // wraps within 32 bits
            taken_q = taken_q + 1'b1;
            w.last  = (int'(taken_q) == sz);
        end
    endtask

    // draw choice: mostly well-formed against the shadow top, some noise
    function automatic logic [swr_pkg::DATA_W-1:0] choose_draw(input bit fresh);
        int lo, top, r, k;
        longint w;
        lo  = span_lo();
        top = top_q;
        if (fresh)
            top = span_hi();
        r = $urandom_range(0, 99);
        w = longint'(top) - longint'(lo);
        if (r < 6 || w < 0)
            return $urandom();
        if (r < 12)
            return $urandom_range(0, 1) ? lo - 1 : top + 1;
        if (r < 27)
            return top;
        if (r < 34)
            return lo;
        // aim at a key already in the table, so the remap path is hit
        if (r < 52 && !fresh)
        begin
            k = $urandom_range(0, swr_pkg::MAX_SAMPLES - 1);
            for (int i = 0; i < swr_pkg::MAX_SAMPLES; i++)
                if (map_used[(k + i) % swr_pkg::MAX_SAMPLES])
                    return map_key[(k + i) % swr_pkg::MAX_SAMPLES];
        end
        return lo + $urandom_range(0, 32'(w));
    endfunction

    // ------------------------------------------------------------------
    // port activity
    // ------------------------------------------------------------------

    // all three registers loaded back to back; only called with the block idle
    task automatic load_config(input logic [swr_pkg::DATA_W-1:0] lo_v,
                               input logic [swr_pkg::DATA_W-1:0] hi_v,
                               input logic [swr_pkg::SIZE_W-1:0] sz_v);
        logic [swr_pkg::DATA_W-1:0]  vals [3];
        logic [swr_pkg::CFG_A_W-1:0] idx  [3];
        // upper bits of the size write are junk, only the low 7 count
        vals = '{lo_v, hi_v, {25'($urandom()), sz_v}};
        idx  = '{swr_pkg::REG_RANGE_LOW, swr_pkg::REG_RANGE_HIGH, swr_pkg::REG_SAMPLE_SIZE};
        for (int k = 0; k < 3; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= idx[k];
            cfg_wdata <= vals[k];
            @(posedge clk);
        end
        cfg_we   <= 1'b0;
        low_reg  = lo_v;
        high_reg = hi_v;
        size_reg = sz_v;
    endtask

    // sender stops and waits until every owed result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
    endtask

    // offer one draw word, hold it until taken, then book its result
    task automatic offer_word(input logic [swr_pkg::DATA_W-1:0] d, input bit fresh,
                              input bit known, input sample_word_t typed);
        sample_word_t w;
        while (!calm && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        draw     <= d;
        restart  <= fresh;
        do
            @(posedge clk);
        while (!in_ready);
        predict_word(d, fresh, w);
        pending_samples.insert(pending_samples.size(), known ? typed : w);
        words_sent++;
    endtask

    task automatic add_cfg(input logic [swr_pkg::DATA_W-1:0] lo_v,
                           input logic [swr_pkg::DATA_W-1:0] hi_v,
                           input logic [swr_pkg::SIZE_W-1:0] sz_v);
        plan_row_t row;
        row          = '{default: '0};
        row.is_cfg   = 1'b1;
        row.lo_reg   = lo_v;
        row.hi_reg   = hi_v;
        row.size_reg = sz_v;
        plan.insert(plan.size(), row);
    endtask

    task automatic add_item(input logic [swr_pkg::DATA_W-1:0] d, input bit fresh,
                            input bit known, input logic [swr_pkg::DATA_W-1:0] value,
                            input bit last, input logic [1:0] err);
        plan_row_t row;
        row            = '{default: '0};
        row.pick       = d;
        row.fresh      = fresh;
        row.known      = known;
        row.want.value = value;
        row.want.last  = last;
        row.want.err   = err;
        plan.insert(plan.size(), row);
    endtask

    // receiver: random stalls, a long hold-off on request, none while calm
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (holds_asked != holds_served)
        begin
            holds_served = holds_served + 1;
            hold_left    = HOLD_CYCLES;
            out_ready    <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    // result check against the oldest owed word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: value %0d last %0b err %0d",
                             sample_value, last_of_sample, error_code);
            end
            else
            begin
                head_word = pending_samples.pop_front();
                if (sample_value !== head_word.value || last_of_sample !== head_word.last
                    || error_code !== head_word.err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want value %0d last %0b err %0d, got %0d %0b %0d",
                                 $signed(head_word.value), head_word.last, head_word.err,
                                 sample_value, last_of_sample, error_code);
                end
            end
        end
    end

    // watchdog on cycles with nothing moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d results still owed", pending_samples.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        longint lo_l, hi_l, width;
        int tmp, cls, n_words;
        logic [swr_pkg::SIZE_W-1:0] sz;
        bit fresh;

        // shadow starts from the reset state
        low_reg  = swr_pkg::RANGE_LOW_RST;
        high_reg = swr_pkg::RANGE_HIGH_RST;
        size_reg = swr_pkg::SAMPLE_SIZE_RST;
        for (int i = 0; i < swr_pkg::MAX_SAMPLES; i++)
        begin
            map_key[i] = '0;
            map_val[i] = '0;
        end
        open_sample();

        // directed plan; typed expectations only where obvious
        // reset registers: range 0..255, one value per sample
        add_item(32'd0, 1'b0, 1'b1, 32'd0, 1'b1, swr_pkg::ERR_OK);
        add_item(32'd5, 1'b0, 1'b1, 32'd0, 1'b0, swr_pkg::ERR_DONE);    // sample complete
        add_item(32'hFFFF_FFFF, 1'b1, 1'b1, 32'd0, 1'b0, swr_pkg::ERR_RANGE); // below low
        add_item(32'd255, 1'b0, 1'b1, 32'd255, 1'b1, swr_pkg::ERR_OK);  // draw equal to top
        add_cfg(32'd0, 32'd255, 7'd64);
        add_item(32'd256, 1'b1, 1'b1, 32'd0, 1'b0, swr_pkg::ERR_RANGE); // above top
        add_item(32'd255, 1'b0, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);
        add_item(32'd3, 1'b0, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);
        add_item(32'd3, 1'b0, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);         // remap hit
        add_item(32'd0, 1'b0, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);
        // size above table depth saturates, applied mid-sample
        add_cfg(32'd0, 32'd255, 7'd127);
        add_item(32'd0, 1'b0, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);
        add_item(32'd0, 1'b1, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);
        // size zero counts as complete
        add_cfg(32'd0, 32'd255, 7'd0);
        add_item(32'd7, 1'b1, 1'b1, 32'd0, 1'b0, swr_pkg::ERR_DONE);
        // reversed bounds
        add_cfg(32'd100, 32'd10, 7'd3);
        add_item(32'd10, 1'b1, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);
        add_item(32'd100, 1'b0, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);
        add_item(32'd99, 1'b0, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);
        add_item(32'd10, 1'b0, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);
        // size larger than the range
        add_cfg(32'd0, 32'd50, 7'd100);
        add_item(32'd0, 1'b1, 1'b1, 32'd0, 1'b0, swr_pkg::ERR_SIZE);
        // full 32-bit range, extremes of the draw
        add_cfg(32'h8000_0000, 32'h7FFF_FFFF, 7'd64);
        add_item(32'h7FFF_FFFF, 1'b1, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);
        add_item(32'h8000_0000, 1'b0, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);
        add_item(32'h7FFF_FFFF, 1'b0, 1'b1, 32'd0, 1'b0, swr_pkg::ERR_RANGE);
        // single-value range at the bottom: top wraps round to the maximum
        add_cfg(32'h8000_0000, 32'h8000_0000, 7'd1);
        add_item(32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b1, swr_pkg::ERR_OK);
        // widen mid-sample, the wrapped top stays in force
        add_cfg(32'h8000_0000, 32'h7FFF_FFFF, 7'd2);
        add_item(32'h7FFF_FFFF, 1'b0, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);
        add_cfg(32'd3, 32'd0, 7'd4);
        add_item(32'd0, 1'b1, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);
        add_item(32'd3, 1'b0, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);
        // raise the low bound above the top mid-sample
        add_cfg(32'd3, 32'd10, 7'd4);
        add_item(32'd3, 1'b0, 1'b0, '0, 1'b0, swr_pkg::ERR_OK);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            if (plan[r].is_cfg)
            begin
                drain_results();
                load_config(plan[r].lo_reg, plan[r].hi_reg, plan[r].size_reg);
            end
            else
                offer_word(plan[r].pick, plan[r].fresh, plan[r].known, plan[r].want);
        end

        // random phases: one register setting each, mostly whole samples
        while (words_sent < TOTAL_WORDS)
        begin
            drain_results();
            cls = $urandom_range(0, 3);
            case (cls)
                0: lo_l = longint'($urandom_range(0, 200)) - 100;
                1: lo_l = INT_MIN + longint'($urandom_range(0, 40));
                2: lo_l = INT_MAX - longint'($urandom_range(0, 200));
                default:
                begin
                    tmp  = $urandom();
                    lo_l = tmp;
                end
            endcase
            tmp = $urandom_range(0, 99);
            if (tmp < 10)
                width = longint'($urandom_range(0, 4));
            else if (tmp < 25)
                width = longint'($urandom());
            else
                width = longint'($urandom_range(0, 100));
            hi_l = lo_l + width;
            if (hi_l > INT_MAX)
                hi_l = INT_MAX;
            tmp = $urandom_range(0, 99);
            if (tmp < 5)
                sz = 7'd0;
            else if (tmp < 15)
                sz = 7'($urandom_range(65, 127));
            else if (tmp < 30)
                sz = 7'($urandom_range(17, 64));
            else
                sz = 7'($urandom_range(1, 16));
            if ($urandom_range(0, 2) == 0)
                load_config(hi_l[31:0], lo_l[31:0], sz);
            else
                load_config(lo_l[31:0], hi_l[31:0], sz);

            n_words = eff_size() + $urandom_range(1, 6);
            for (int j = 0; j < n_words && words_sent < TOTAL_WORDS; j++)
            begin
                // occasionally carry the old sample into the new setting
                if (j == 0)
                    fresh = ($urandom_range(0, 9) != 0);
                else if (int'(taken_q) >= eff_size())
                    fresh = ($urandom_range(0, 3) != 0);
                else
                    fresh = ($urandom_range(0, 99) < 3);
                calm = (words_sent >= CALM_FROM && words_sent < CALM_TO);
                // receiver holds off while the sender keeps offering
                if (holds_asked == 0 && words_sent >= HOLD_AT_WORD && n_words - j >= 3)
                    holds_asked++;
                offer_word(choose_draw(fresh), fresh, 1'b0, '0);
            end
        end

        drain_results();
        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
